>>> rtl/bbps_pkg.sv
package bbps_pkg;

  localparam int VW = 24;
  localparam int GW = 16;
  localparam int PW = VW + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY_ACCEL,
    REG_BOUNCE_GAIN,
    REG_FLOOR_DRAG,
    REG_STOP_THRESHOLD,
    REG_BOUND_LEFT,
    REG_BOUND_RIGHT,
    REG_BOUND_TOP,
    REG_BOUND_BOTTOM
  } cfg_reg_t;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } mode_t;

  typedef struct packed {
    logic                 mode;
    logic [GW-1:0]        delta_time;
    logic signed [VW-1:0] load_pos_x;
    logic signed [VW-1:0] load_pos_y;
    logic signed [VW-1:0] load_vel_x;
    logic signed [VW-1:0] load_vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [VW-1:0] pos_x;
    logic signed [VW-1:0] pos_y;
    logic signed [VW-1:0] vel_x;
    logic signed [VW-1:0] vel_y;
    logic                 stopped;
  } out_item_t;

  typedef enum logic [2:0] {
    M_GRAV,
    M_VX_DT,
    M_VY_DT,
    M_NVY_GAIN,
    M_VX_DRAG,
    M_NVX_GAIN
  } mul_sel_t;

  typedef enum logic [2:0] {
    U_NONE,
    U_VY_ADD,
    U_X_ADD,
    U_Y_ADD,
    U_VY_SET,
    U_VX_SET
  } upd_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    upd_t     upd;
    logic     stop_chk;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic at_rest;
    logic hit_bottom;
    logic hit_top;
    logic hit_x;
  } sts_t;

endpackage

>>> rtl/bbps_ctrl.sv
module bbps_ctrl
  import bbps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRAV,
    S_VY,
    S_PX,
    S_PY,
    S_YHIT,
    S_YSET,
    S_DRAG,
    S_XHIT,
    S_XSET,
    S_STOP,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = M_GRAV;
    cmd.upd      = U_NONE;
    cmd.capture  = accept;
    state_nxt    = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD || sts.at_rest) state_nxt = S_FINISH;
          else state_nxt = S_GRAV;
        end
      end
      S_GRAV: begin
        cmd.mul_sel = M_GRAV;
        state_nxt   = S_VY;
      end
      S_VY: begin
        cmd.upd     = U_VY_ADD;
        cmd.mul_sel = M_VX_DT;
        state_nxt   = S_PX;
      end
      S_PX: begin
        cmd.upd     = U_X_ADD;
        cmd.mul_sel = M_VY_DT;
        state_nxt   = S_PY;
      end
      S_PY: begin
        cmd.upd   = U_Y_ADD;
        state_nxt = S_YHIT;
      end
      S_YHIT: begin
        cmd.mul_sel = M_NVY_GAIN;
        if (sts.hit_bottom || sts.hit_top) state_nxt = S_YSET;
        else state_nxt = S_XHIT;
      end
      S_YSET: begin
        cmd.upd     = U_VY_SET;
        cmd.mul_sel = M_VX_DRAG;
        if (sts.hit_bottom) state_nxt = S_DRAG;
        else state_nxt = S_XHIT;
      end
      S_DRAG: begin
        cmd.upd   = U_VX_SET;
        state_nxt = S_XHIT;
      end
      S_XHIT: begin
        cmd.mul_sel = M_NVX_GAIN;
        if (sts.hit_x) state_nxt = S_XSET;
        else state_nxt = S_STOP;
      end
      S_XSET: begin
        cmd.upd   = U_VX_SET;
        state_nxt = S_STOP;
      end
      S_STOP: begin
        cmd.stop_chk = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bbps_datapath.sv
module bbps_datapath
  import bbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VW-1:0]        cfg_data,
  input  in_item_t             in_data,
  output out_item_t            out_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [VW-2:0]        grav_r;
  logic [GW-1:0]        gain_r;
  logic [GW-1:0]        drag_r;
  logic [VW-2:0]        thr_r;
  logic signed [VW-1:0] left_r, right_r, top_r, bottom_r;

  logic signed [VW-1:0] x_r, y_r, vx_r, vy_r;
  logic                 rest_r;
  logic                 hit_bot_r, hit_top_r, hit_x_r;
  logic [GW-1:0]        dt_r;
  logic signed [PW-1:0] prod_r;
  out_item_t            out_r;

  logic signed [PW-1:0]   mul_a;
  logic signed [GW:0]     mul_b;
  logic signed [PW+GW:0]  prod;
  logic signed [VW+1:0]   prod_ext;
  logic signed [VW-1:0]   sum_x, sum_y, sum_vy, prod_sat;
  logic [VW-1:0]          abs_x, abs_y;
  logic [VW:0]            speed_sum;
  logic                   slow;

  function automatic logic signed [VW-1:0] sat_val(input logic signed [VW+1:0] v);
    logic signed [VW+1:0] hi;
    logic signed [VW+1:0] lo;
    logic signed [VW-1:0] r;
    hi = {3'b000, {(VW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) r = hi[VW-1:0];
    else if (v < lo) r = lo[VW-1:0];
    else r = v[VW-1:0];
    return r;
  endfunction

  function automatic logic signed [VW+1:0] ext2(input logic signed [VW-1:0] v);
    return {{2{v[VW-1]}}, v};
  endfunction

  function automatic logic signed [PW-1:0] ext1(input logic signed [VW-1:0] v);
    return {v[VW-1], v};
  endfunction

  always_comb begin
    unique case (cmd.mul_sel)
      M_GRAV: begin
        mul_a = {2'b00, grav_r};
        mul_b = {1'b0, dt_r};
      end
      M_VX_DT: begin
        mul_a = ext1(vx_r);
        mul_b = {1'b0, dt_r};
      end
      M_VY_DT: begin
        mul_a = ext1(vy_r);
        mul_b = {1'b0, dt_r};
      end
      M_NVY_GAIN: begin
        mul_a = -ext1(vy_r);
        mul_b = {1'b0, gain_r};
      end
      M_VX_DRAG: begin
        mul_a = ext1(vx_r);
        mul_b = {1'b0, drag_r};
      end
      M_NVX_GAIN: begin
        mul_a = -ext1(vx_r);
        mul_b = {1'b0, gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  assign prod_ext  = {prod_r[PW-1], prod_r};
  assign sum_vy    = sat_val(ext2(vy_r) + prod_ext);
  assign sum_x     = sat_val(ext2(x_r) + prod_ext);
  assign sum_y     = sat_val(ext2(y_r) + prod_ext);
  assign prod_sat  = sat_val(prod_ext);
  assign abs_x     = vx_r[VW-1] ? (~vx_r + 1'b1) : vx_r;
  assign abs_y     = vy_r[VW-1] ? (~vy_r + 1'b1) : vy_r;
  assign speed_sum = {1'b0, abs_x} + {1'b0, abs_y};
  assign slow      = speed_sum < {2'b00, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r   <= '0;
      gain_r   <= '0;
      drag_r   <= '1;
      thr_r    <= '0;
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRAVITY_ACCEL:  grav_r   <= cfg_data[VW-2:0];
        REG_BOUNCE_GAIN:    gain_r   <= cfg_data[GW-1:0];
        REG_FLOOR_DRAG:     drag_r   <= cfg_data[GW-1:0];
        REG_STOP_THRESHOLD: thr_r    <= cfg_data[VW-2:0];
        REG_BOUND_LEFT:     left_r   <= cfg_data;
        REG_BOUND_RIGHT:    right_r  <= cfg_data;
        REG_BOUND_TOP:      top_r    <= cfg_data;
        REG_BOUND_BOTTOM:   bottom_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod[PW+GW-1:GW];
    if (cmd.capture) dt_r <= in_data.delta_time;
    if (cmd.out_load) begin
      out_r.pos_x   <= x_r;
      out_r.pos_y   <= y_r;
      out_r.vel_x   <= vx_r;
      out_r.vel_y   <= vy_r;
      out_r.stopped <= rest_r;
    end
    unique case (cmd.upd)
      U_X_ADD: begin
        if (sum_x <= left_r) begin
          hit_x_r <= 1'b1;
        end else if (sum_x >= right_r) begin
          hit_x_r <= 1'b1;
        end else begin
          hit_x_r <= 1'b0;
        end
      end
      U_Y_ADD: begin
        hit_bot_r <= (sum_y >= bottom_r);
        hit_top_r <= (sum_y < bottom_r) && (sum_y <= top_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      vx_r   <= '0;
      vy_r   <= '0;
      rest_r <= 1'b0;
    end else if (cmd.capture && in_data.mode == MODE_LOAD) begin
      x_r    <= in_data.load_pos_x;
      y_r    <= in_data.load_pos_y;
      vx_r   <= in_data.load_vel_x;
      vy_r   <= in_data.load_vel_y;
      rest_r <= 1'b0;
    end else if (cmd.stop_chk) begin
      if (slow) begin
        rest_r <= 1'b1;
        vx_r   <= '0;
        vy_r   <= '0;
      end
    end else begin
      unique case (cmd.upd)
        U_VY_ADD: vy_r <= sum_vy;
        U_X_ADD: begin
          priority if (sum_x <= left_r) x_r <= left_r;
          else if (sum_x >= right_r) x_r <= right_r;
          else x_r <= sum_x;
        end
        U_Y_ADD: begin
          priority if (sum_y >= bottom_r) y_r <= bottom_r;
          else if (sum_y <= top_r) y_r <= top_r;
          else y_r <= sum_y;
        end
        U_VY_SET: vy_r <= prod_sat;
        U_VX_SET: vx_r <= prod_sat;
        default: ;
      endcase
    end
  end

  assign out_data       = out_r;
  assign sts.at_rest    = rest_r;
  assign sts.hit_bottom = hit_bot_r;
  assign sts.hit_top    = hit_top_r;
  assign sts.hit_x      = hit_x_r;

endmodule

>>> rtl/bouncing_ball_physics_step.sv
// channel  direction  handshake             payload
// in       input      in_valid/in_ready     in_data (in_item_t)
// out      output     out_valid/out_ready   out_data (out_item_t)
// cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A tick steps from transfer to result through the multiply and update states: one shared 25x17 multiplier
// serves gravity, motion, bounce and drag products in turn, one product a cycle.
// A load item, or a tick while at rest, goes straight from the transfer to the finish state.
// Synchronous active-low reset clears the ball state and restores register defaults.
// A result waiting in the output register stalls only the next result, not the next transfer.
// cfg_ready is always high.
module bouncing_ball_physics_step
  import bbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VW-1:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bbps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbps_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/bbps_checker.sv
module bbps_checker
  import bbps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transfer taken while an item is at work");

  a_rest_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stopped |-> out_data.vel_x == '0 && out_data.vel_y == '0)
    else $error("ball at rest with nonzero velocity");

endmodule

bind bouncing_ball_physics_step bbps_checker u_chk (.*);

>>> tb/tb_top.sv
module tb_top;
  import bbps_pkg::*;

  localparam longint VAL_MAX = (longint'(1) << (VW - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 165;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;
  typedef enum {PLAN_SCENE, PLAN_EXTREME, PLAN_RANDOM} plan_kind_t;

  class ball_scoreboard;
    out_item_t expected_q[$];
    int errors;
    longint gravity, gain, drag, threshold;
    longint left, right, top, bottom;
    longint bx, by, vx, vy;
    bit resting;

    function new();
      errors = 0;
      gravity = 0;
      gain = 0;
      drag = 65535;
      threshold = 0;
      left = 0;
      right = 0;
      top = 0;
      bottom = 0;
      bx = 0;
      by = 0;
      vx = 0;
      vy = 0;
      resting = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [VW-1:0] data);
      case (idx)
        REG_GRAVITY_ACCEL:  gravity = data[VW-2:0];
        REG_BOUNCE_GAIN:    gain = data[GW-1:0];
        REG_FLOOR_DRAG:     drag = data[GW-1:0];
        REG_STOP_THRESHOLD: threshold = data[VW-2:0];
        REG_BOUND_LEFT:     left = $signed(data);
        REG_BOUND_RIGHT:    right = $signed(data);
        REG_BOUND_TOP:      top = $signed(data);
        REG_BOUND_BOTTOM:   bottom = $signed(data);
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
    endfunction

    // floor of the product with a Q0.16 factor
    function longint scale(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      longint dt, nx, ny;
      dt = it.delta_time;
      if (it.mode == MODE_LOAD) begin
        bx = $signed(it.load_pos_x);
        by = $signed(it.load_pos_y);
        vx = $signed(it.load_vel_x);
        vy = $signed(it.load_vel_y);
        resting = 1'b0;
      end else if (!resting) begin
        vy = clip(vy + scale(gravity, dt));
        nx = clip(bx + scale(vx, dt));
        ny = clip(by + scale(vy, dt));
        if (ny >= bottom) begin
          ny = bottom;
          vy = clip(scale(-vy, gain));
          vx = clip(scale(vx, drag));
        end else if (ny <= top) begin
          ny = top;
          vy = clip(scale(-vy, gain));
        end
        if (nx <= left) begin
          nx = left;
          vx = clip(scale(-vx, gain));
        end else if (nx >= right) begin
          nx = right;
          vx = clip(scale(-vx, gain));
        end
        bx = nx;
        by = ny;
        if (mag(vx) + mag(vy) < threshold) begin
          resting = 1'b1;
          vx = 0;
          vy = 0;
        end
      end
      r.pos_x = bx[VW-1:0];
      r.pos_y = by[VW-1:0];
      r.vel_x = vx[VW-1:0];
      r.vel_y = vy[VW-1:0];
      r.stopped = resting;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [VW-1:0] e, logic [VW-1:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(out_item_t act);
      out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, act);
        return;
      end
      e = expected_q.pop_front();
      compare_field("pos_x", e.pos_x, act.pos_x);
      compare_field("pos_y", e.pos_y, act.pos_y);
      compare_field("vel_x", e.vel_x, act.vel_x);
      compare_field("vel_y", e.vel_y, act.vel_y);
      compare_field("stopped", VW'(e.stopped), VW'(act.stopped));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VW-1:0]        cfg_data;

  ball_scoreboard sb;
  logic [VW-1:0]  cfg_plan [1 << CFG_IDX_W];
  bit             valid_high;
  bit             long_hold_req;
  int             burst_left;
  int             items_done;
  int             cycles;

  bouncing_ball_physics_step u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    int       rx_cycle;
    int       hold_left;
    rx_mode_t rx_mode;
    bit       ready_next;
    rx_cycle = 0;
    hold_left = 0;
    rx_mode = RX_OPEN;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     ready_next = 1'b1;
          RX_RANDOM:   ready_next = ($urandom_range(0, 99) < 70);
          RX_PERIODIC: ready_next = ((rx_cycle % 7) < 3);
          default:     ready_next = ($urandom_range(0, 9) == 0);
        endcase
      end
      out_ready <= ready_next;
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode = 1'($urandom_range(0, 1));
    it.delta_time = GW'($urandom);
    it.load_pos_x = VW'($urandom);
    it.load_pos_y = VW'($urandom);
    it.load_vel_x = VW'($urandom);
    it.load_vel_y = VW'($urandom);
    return it;
  endfunction

  function automatic logic [GW-1:0] pick_dt();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return GW'($urandom_range(800, 1400));
    if (r < 70) return GW'($urandom);
    if (r < 80) return '0;
    if (r < 90) return '1;
    return GW'($urandom_range(1, 16));
  endfunction

  function automatic longint pick_speed();
    int unsigned vmag;
    case ($urandom_range(0, 2))
      0:       vmag = 2000;
      1:       vmag = 40000;
      default: vmag = 400000;
    endcase
    return longint'($urandom_range(0, 2 * vmag)) - vmag;
  endfunction

  function automatic in_item_t make_load(bit wild);
    in_item_t it;
    longint   w, h, x, y, sx, sy;
    it = random_item();
    it.mode = MODE_LOAD;
    w = sb.right - sb.left;
    h = sb.bottom - sb.top;
    if (!wild && w > 0 && h > 0) begin
      x = sb.left + $urandom_range(0, int'(w));
      y = sb.top + $urandom_range(0, int'(h));
      sx = pick_speed();
      sy = pick_speed();
      it.load_pos_x = x[VW-1:0];
      it.load_pos_y = y[VW-1:0];
      it.load_vel_x = sx[VW-1:0];
      it.load_vel_y = sy[VW-1:0];
    end
    return it;
  endfunction

  function automatic logic [VW-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return VAL_MIN[VW-1:0];
      1:       return VAL_MAX[VW-1:0];
      2:       return '0;
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic make_plan(plan_kind_t kind);
    longint lo, hi, sz;
    case (kind)
      PLAN_SCENE: begin
        cfg_plan[REG_GRAVITY_ACCEL] = VW'($urandom_range(0, 100000));
        cfg_plan[REG_GRAVITY_ACCEL][VW-1] = 1'($urandom_range(0, 1));
        cfg_plan[REG_BOUNCE_GAIN] = VW'($urandom_range(30000, 65535));
        cfg_plan[REG_BOUNCE_GAIN][VW-1:GW] = 8'($urandom);
        cfg_plan[REG_FLOOR_DRAG] = VW'($urandom_range(40000, 65535));
        cfg_plan[REG_FLOOR_DRAG][VW-1:GW] = 8'($urandom);
        cfg_plan[REG_STOP_THRESHOLD] =
          ($urandom_range(0, 4) == 0) ? '0 : VW'($urandom_range(1, 5000));
        cfg_plan[REG_STOP_THRESHOLD][VW-1] = 1'($urandom_range(0, 1));
        lo = longint'($urandom_range(0, 40000)) - 20000;
        sz = $urandom_range(2000, 200000);
        hi = lo + sz;
        cfg_plan[REG_BOUND_LEFT] = lo[VW-1:0];
        cfg_plan[REG_BOUND_RIGHT] = hi[VW-1:0];
        lo = longint'($urandom_range(0, 40000)) - 20000;
        sz = $urandom_range(2000, 200000);
        hi = lo + sz;
        cfg_plan[REG_BOUND_TOP] = lo[VW-1:0];
        cfg_plan[REG_BOUND_BOTTOM] = hi[VW-1:0];
      end
      PLAN_EXTREME: begin
        foreach (cfg_plan[i]) cfg_plan[i] = extreme_value();
      end
      default: begin
        foreach (cfg_plan[i]) cfg_plan[i] = VW'($urandom);
      end
    endcase
  endtask

  task automatic program_registers();
    cfg_reg_t r;
    for (int i = 0; i < r.num(); i++) begin
      r = cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= cfg_plan[r];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(r, cfg_plan[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(in_item_t it);
    bit counts;
    in_valid <= 1'b1;
    in_data <= it;
    valid_high = 1'b1;
    do @(posedge clk); while (!in_ready);
    counts = (it.mode == MODE_LOAD) || !sb.resting;
    sb.note_input(it);
    if (counts) items_done++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      valid_high = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_idle();
    if (valid_high) begin
      in_valid <= 1'b0;
      valid_high = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_ball(longint x, longint y, longint sx, longint sy);
    in_item_t it;
    it = random_item();
    it.mode = MODE_LOAD;
    it.load_pos_x = x[VW-1:0];
    it.load_pos_y = y[VW-1:0];
    it.load_vel_x = sx[VW-1:0];
    it.load_vel_y = sy[VW-1:0];
    send_item(it);
  endtask

  task automatic tick_ball(int dt);
    in_item_t it;
    it = random_item();
    it.mode = MODE_TICK;
    it.delta_time = GW'(dt);
    send_item(it);
  endtask

  task automatic run_sequence(bit wild);
    int unsigned roll;
    int          run;
    in_item_t    it;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 3)) send_item(random_item());
    end else begin
      if (roll >= 12) send_item(make_load(wild || $urandom_range(0, 9) == 0));
      run = $urandom_range(1, 50);
      for (int i = 0; i < run; i++) begin
        it = random_item();
        it.mode = MODE_TICK;
        it.delta_time = pick_dt();
        send_item(it);
        if (sb.resting && $urandom_range(0, 1) == 0) break;
      end
    end
  endtask

  initial begin
    int         target;
    plan_kind_t kind;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    valid_high = 1'b0;
    long_hold_req = 1'b0;
    burst_left = 0;
    items_done = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero bounds, full floor drag
    load_ball(5000, -3000, 2000, 700);
    tick_ball(1092);

    wait_idle();
    cfg_plan[REG_GRAVITY_ACCEL] = VW'(51200);
    cfg_plan[REG_BOUNCE_GAIN] = VW'(52429);
    cfg_plan[REG_FLOOR_DRAG] = VW'(58982);
    cfg_plan[REG_STOP_THRESHOLD] = VW'(2560);
    cfg_plan[REG_BOUND_LEFT] = '0;
    cfg_plan[REG_BOUND_RIGHT] = VW'(153600);
    cfg_plan[REG_BOUND_TOP] = '0;
    cfg_plan[REG_BOUND_BOTTOM] = VW'(102400);
    program_registers();
    load_ball(25600, 25600, 12800, -7680);
    tick_ball(1092);
    tick_ball(0);
    tick_ball(65535);
    load_ball(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
    tick_ball(65535);
    load_ball(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
    tick_ball(65535);
    load_ball(76800, 102300, 1000, 5000);
    tick_ball(1092);
    load_ball(76800, 100, 0, -20000);
    tick_ball(1092);
    load_ball(5, 50000, -20000, 0);
    tick_ball(1092);
    load_ball(153500, 50000, 20000, 0);
    tick_ball(1092);
    load_ball(76800, 102400, 100, 100);
    tick_ball(1);
    tick_ball(65535);
    load_ball(0, 0, 0, 0);

    // crossed bounds, full gain, no drag, never rests
    wait_idle();
    cfg_plan[REG_GRAVITY_ACCEL] = '1;
    cfg_plan[REG_BOUNCE_GAIN] = '1;
    cfg_plan[REG_FLOOR_DRAG] = '0;
    cfg_plan[REG_STOP_THRESHOLD] = '0;
    cfg_plan[REG_BOUND_LEFT] = VAL_MAX[VW-1:0];
    cfg_plan[REG_BOUND_RIGHT] = VAL_MIN[VW-1:0];
    cfg_plan[REG_BOUND_TOP] = VAL_MAX[VW-1:0];
    cfg_plan[REG_BOUND_BOTTOM] = VAL_MIN[VW-1:0];
    program_registers();
    load_ball(0, 0, 1000, -1000);
    tick_ball(65535);

    // widest bounds, largest threshold
    wait_idle();
    cfg_plan[REG_GRAVITY_ACCEL] = '0;
    cfg_plan[REG_BOUNCE_GAIN] = '0;
    cfg_plan[REG_STOP_THRESHOLD] = VAL_MAX[VW-1:0];
    cfg_plan[REG_BOUND_LEFT] = VAL_MIN[VW-1:0];
    cfg_plan[REG_BOUND_RIGHT] = VAL_MAX[VW-1:0];
    cfg_plan[REG_BOUND_TOP] = VAL_MIN[VW-1:0];
    cfg_plan[REG_BOUND_BOTTOM] = VAL_MAX[VW-1:0];
    program_registers();
    load_ball(-40000, 30000, 300000, -200000);
    tick_ball(1000);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 5)
        3:       kind = PLAN_EXTREME;
        4:       kind = PLAN_RANDOM;
        default: kind = PLAN_SCENE;
      endcase
      make_plan(kind);
      program_registers();
      if (ph == 2 || ph == 6) long_hold_req = 1'b1;
      target = items_done + PHASE_ITEMS;
      while (items_done < target) run_sequence(kind != PLAN_SCENE);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
